[sv/radix_digit_emitter_core_macros.svh]
// Assertion macros shared by the radix digit emitter.
`ifndef RADIX_DIGIT_EMITTER_CORE_MACROS_SVH
`define RADIX_DIGIT_EMITTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("radix digit emitter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("radix digit emitter: next-cycle check failed");

`endif

[sv/rde_pkg.sv]
package rde_pkg;

	// Field widths.
	localparam int VALUE_W = 31;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;
	localparam int STEP_W  = $clog2(VALUE_W);

	// Default depth of the digit stack.
	localparam int DIGIT_DEPTH_DEF = 32;

	// Radix limits and reset value.
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

	// Character mapping constants.
	localparam logic [DIGIT_W-1:0] LETTER_LIMIT  = 4'd9;
	localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;
	localparam logic [CHAR_W-1:0]  NUMBER_OFFSET = 7'd48;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_READ,
		ST_LOAD
	} rde_state_t;

	// Clamp the programmed radix into the supported range.
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// Map a digit to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d > LETTER_LIMIT) begin
			res = CHAR_W'(d) + LETTER_OFFSET;
		end else begin
			res = CHAR_W'(d) + NUMBER_OFFSET;
		end
		return res;
	endfunction

endpackage

[sv/radix_digit_emitter_core.sv]
// Radix digit emitter.
// Input stream (s_*): one transfer carries a non-negative value to convert.
// Config channel (cfg_*): writes the radix (2..16, values outside are clamped).
// Write it only while the block is idle. Reset leaves the radix at 10.
// Output stream (m_*): one transfer per ASCII digit, most significant first;
// m_tlast marks the least significant digit. Zero gives the single digit '0'.
// Each digit is found by a bit-serial restoring division of the value by the
// radix, one quotient bit per cycle, followed by a push of the remainder on
// the digit stack. Popping a digit passes through a read state and a load
// state. A value has at most 31 binary digits; one value is held at a time.
// A stall on m_tready holds the output register and pauses the pop sequence.
// The next value is accepted once the last digit sits in the output register.
// Reset (arst_n low) returns the block to idle with an empty digit stack and
// no output pending; the stack needs no clearing pass.
`include "radix_digit_emitter_core_macros.svh"

module radix_digit_emitter_core #(
	parameter int DIGIT_DEPTH = rde_pkg::DIGIT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data,    // [4:0] radix
	// Input stream.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [31:0] s_tdata,    // [30:0] value, [31] zero fill
	// Output stream.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,     // [6:0] char_code, [7] zero fill
	output logic       m_tlast      // last_char
);

	localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
	localparam int IDX_W = $clog2(DIGIT_DEPTH);

	rde_pkg::rde_state_t state_q, state_d;

	logic [rde_pkg::RADIX_W-1:0] radix_q;
	logic [rde_pkg::RADIX_W-1:0] base_q;
	logic [rde_pkg::VALUE_W-1:0] quo_q;
	logic [rde_pkg::DIGIT_W-1:0] rem_q;
	logic                        nz_q;
	logic [rde_pkg::STEP_W-1:0]  bit_cnt_q;
	logic [CNT_W-1:0]            count_q;
	logic [rde_pkg::DIGIT_W-1:0] rd_q;
	logic                        m_tvalid_q;
	logic [rde_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;

	logic [rde_pkg::DIGIT_W-1:0] store_mem [DIGIT_DEPTH];

	logic                        in_xfer;
	logic                        out_free;
	logic [rde_pkg::RADIX_W-1:0] trial;
	logic                        trial_ge;
	logic [rde_pkg::RADIX_W-1:0] trial_sub;
	logic                        push_ok;
	logic [CNT_W-1:0]            count_dec;
	logic                        load_out;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == rde_pkg::ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {1'b0, char_q};
	assign m_tlast   = last_q;

	// One restoring division step: bring down the next dividend bit.
	assign trial     = {rem_q, quo_q[rde_pkg::VALUE_W-1]};
	assign trial_ge  = (trial >= base_q);
	assign trial_sub = trial - base_q;

	assign push_ok   = (count_q != CNT_W'(DIGIT_DEPTH));
	assign count_dec = count_q - CNT_W'(1);
	assign load_out  = (state_q == rde_pkg::ST_LOAD) && out_free;

	// Radix register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rde_pkg::RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rde_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rde_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = rde_pkg::ST_DIV;
				end
			end
			rde_pkg::ST_DIV: begin
				if (bit_cnt_q == '0) begin
					state_d = rde_pkg::ST_PUSH;
				end
			end
			rde_pkg::ST_PUSH: begin
				if (nz_q) begin
					state_d = rde_pkg::ST_DIV;
				end else begin
					state_d = rde_pkg::ST_READ;
				end
			end
			rde_pkg::ST_READ: begin
				state_d = rde_pkg::ST_LOAD;
			end
			rde_pkg::ST_LOAD: begin
				if (out_free) begin
					state_d = (count_q == '0) ? rde_pkg::ST_IDLE : rde_pkg::ST_READ;
				end
			end
			default: begin
				state_d = rde_pkg::ST_IDLE;
			end
		endcase
	end

	// Control counters: division step count and stack fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			count_q   <= '0;
		end else begin
			if (in_xfer || ((state_q == rde_pkg::ST_PUSH) && nz_q)) begin
				bit_cnt_q <= rde_pkg::STEP_W'(rde_pkg::VALUE_W - 1);
			end else if (state_q == rde_pkg::ST_DIV) begin
				bit_cnt_q <= bit_cnt_q - rde_pkg::STEP_W'(1);
			end
			if ((state_q == rde_pkg::ST_PUSH) && push_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (state_q == rde_pkg::ST_READ) begin
				count_q <= count_dec;
			end
		end
	end

	// Division datapath: quotient shifts left, remainder collects one bit a cycle.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			quo_q  <= s_tdata[rde_pkg::VALUE_W-1:0];
			rem_q  <= '0;
			nz_q   <= 1'b0;
			base_q <= rde_pkg::eff_radix(radix_q);
		end else if (state_q == rde_pkg::ST_DIV) begin
			quo_q <= {quo_q[rde_pkg::VALUE_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[rde_pkg::DIGIT_W-1:0]
			                  : trial[rde_pkg::DIGIT_W-1:0];
			nz_q  <= nz_q | trial_ge;
		end else if (state_q == rde_pkg::ST_PUSH) begin
			rem_q <= '0;
			nz_q  <= 1'b0;
		end
	end

	// Digit stack: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if ((state_q == rde_pkg::ST_PUSH) && push_ok) begin
			store_mem[count_q[IDX_W-1:0]] <= rem_q;
		end
		if (state_q == rde_pkg::ST_READ) begin
			rd_q <= store_mem[count_dec[IDX_W-1:0]];
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= rde_pkg::digit_char(rd_q);
			last_q <= (count_q == '0);
		end
	end

	// Checks on the sequencer and the division.
	`RDE_ASSERT_IMPL(a_idle_empty, clk, arst_n, state_q == rde_pkg::ST_IDLE, count_q == '0)
	`RDE_ASSERT_IMPL(a_rem_below_base, clk, arst_n, state_q == rde_pkg::ST_DIV, {1'b0, rem_q} < base_q)
	`RDE_ASSERT_IMPL(a_fill_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DIGIT_DEPTH))
	`RDE_ASSERT_NEXT(a_start_div, clk, arst_n, in_xfer, state_q == rde_pkg::ST_DIV)

endmodule
